// ----- sv/thermistor_avg_temperature_top_assert.svh -----
// Assertion macros used by the thermistor temperature core.
`ifndef THERMISTOR_AVG_TEMPERATURE_TOP_ASSERT_SVH
`define THERMISTOR_AVG_TEMPERATURE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAVG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/tavg_pkg.sv -----
// Types and constants shared by the thermistor temperature modules.
`timescale 1ns / 1ps

package tavg_pkg;

  // Field widths
  localparam int CODE_W  = 16;
  localparam int AVG_W   = 24;
  localparam int TC_W    = 16;
  localparam int TF_W    = 17;
  localparam int ST_W    = 2;
  localparam int LSB_W   = 18;
  localparam int SUP_W   = 23;
  localparam int FIX_W   = 20;
  localparam int COEF_W  = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LSB    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C = 3'd5;

  localparam logic [LSB_W-1:0]  RST_LSB    = 18'd31250;
  localparam logic [SUP_W-1:0]  RST_SUPPLY = 23'd3300000;
  localparam logic [FIX_W-1:0]  RST_FIXED  = 20'd2700;
  localparam logic [COEF_W-1:0] RST_COEF_A = 32'd1237290167;
  localparam logic [COEF_W-1:0] RST_COEF_B = 32'd258127500;
  localparam logic [COEF_W-1:0] RST_COEF_C = 32'd94188;

  // Status codes
  localparam logic [ST_W-1:0] ST_VALID = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_SAT   = 2'd2;

  // Digit-serial multiplier: 40 x 32 bits, four multiplier bits per cycle
  localparam int MUL_AW    = 40;
  localparam int MUL_BW    = 32;
  localparam int MUL_DIG   = 4;
  localparam int MUL_PW    = MUL_AW + MUL_BW;
  localparam int MUL_STEPS = MUL_BW / MUL_DIG;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS + 1);

  // Bit-serial restoring divider
  localparam int DIV_NW    = 56;
  localparam int DIV_DW    = 54;
  localparam int DIV_CNT_W = $clog2(DIV_NW + 1);

  // Datapath widths of the temperature sequence
  localparam int LOG_W   = 24;
  localparam int MANT_W  = 31;
  localparam int EXP_W   = 5;
  localparam int LG_W    = 33;
  localparam int LQM_W   = 23;
  localparam int INNER_W = 37;
  localparam int S_W     = 54;
  localparam int SQ_CNT_W = 5;

  // Constants of the conversion
  localparam logic [MUL_BW-1:0] LN2_Q30      = 32'd744261118;
  localparam logic [AVG_W-1:0]  AVG_MAX      = 24'h7FFFFF;
  localparam logic [AVG_W-1:0]  AVG_MIN      = 24'h800000;
  localparam logic [TC_W-1:0]   KELVIN_CENTI = 16'd27315;
  localparam logic [TC_W-1:0]   TC_LIMIT     = 16'd30000;
  localparam logic [DIV_NW-1:0] CK_LIMIT     = 56'd57315;
  localparam logic [DIV_NW-1:0] CK_NUM       = 56'd100 << 40;
  localparam logic [TF_W-1:0]   TF_OFFSET    = 17'd3200;
  localparam logic [DIV_DW-1:0] TF_DIVISOR   = 54'd5;

  typedef struct packed {
    logic [LSB_W-1:0]  lsb;
    logic [SUP_W-1:0]  supply;
    logic [FIX_W-1:0]  fixed;
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [COEF_W-1:0] coef_c;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] n;
    logic [DIV_DW-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic                     upd;
    logic signed [CODE_W-1:0] code;
  } ring_req_t;

  typedef struct packed {
    logic             valid;
    logic [AVG_W-1:0] avg;
    logic [TC_W-1:0]  tc;
    logic [TF_W-1:0]  tf;
    logic [ST_W-1:0]  status;
  } res_t;

endpackage

// ----- sv/tavg_mul.sv -----
// Digit-serial unsigned multiplier, one multiplier digit per cycle.
`timescale 1ns / 1ps

module tavg_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  tavg_pkg::mul_req_t req,
  output tavg_pkg::mul_rsp_t rsp
);
  import tavg_pkg::*;

  logic [MUL_AW-1:0]         a_r;
  logic [MUL_BW-1:0]         b_r;
  logic [MUL_PW-1:0]         acc_r, acc_nxt;
  logic [MUL_CNT_W-1:0]      cnt_r;
  logic                      done_r;
  logic [MUL_AW+MUL_DIG-1:0] pp;
  logic [MUL_AW+MUL_DIG-1:0] upper;

  // Add the digit's partial product at the top, then shift right by a digit.
  always_comb begin
    pp      = (MUL_AW+MUL_DIG)'(a_r) * (MUL_AW+MUL_DIG)'(b_r[MUL_DIG-1:0]);
    upper   = (MUL_AW+MUL_DIG)'(acc_r[MUL_PW-1:MUL_BW]) + pp;
    acc_nxt = {upper, acc_r[MUL_BW-1:MUL_DIG]};
  end

  // Operand loading and the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        a_r   <= req.a;
        b_r   <= req.b;
        acc_r <= '0;
        cnt_r <= MUL_CNT_W'(MUL_STEPS);
      end else if (cnt_r != '0) begin
        acc_r  <= acc_nxt;
        b_r    <= b_r >> MUL_DIG;
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == MUL_CNT_W'(1));
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

// ----- sv/tavg_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tavg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tavg_pkg::div_req_t req,
  output tavg_pkg::div_rsp_t rsp
);
  import tavg_pkg::*;

  logic [DIV_DW-1:0]    d_r;
  logic [DIV_DW-1:0]    rem_r;
  logic [DIV_NW-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [DIV_DW:0]      trial;
  logic [DIV_DW:0]      diff;
  logic                 ge;

  // Bring down the next numerator bit and try the subtraction.
  always_comb begin
    trial = {rem_r, quo_r[DIV_NW-1]};
    diff  = trial - {1'b0, d_r};
    ge    = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        d_r   <= req.d;
        rem_r <= '0;
        quo_r <= req.n;
        cnt_r <= DIV_CNT_W'(DIV_NW);
      end else if (cnt_r != '0) begin
        rem_r  <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        quo_r  <= {quo_r[DIV_NW-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == DIV_CNT_W'(1));
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = quo_r;

endmodule

// ----- sv/tavg_ring.sv -----
// Ring of the most recent ADC codes with its running sum.
`timescale 1ns / 1ps

module tavg_ring #(
  parameter int WINDOW = 30
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  tavg_pkg::ring_req_t                           req,
  output logic signed [tavg_pkg::CODE_W+$clog2(WINDOW)-1:0] sum,
  output logic                                          done
);
  import tavg_pkg::*;

  localparam int SUM_W  = CODE_W + $clog2(WINDOW);
  localparam int SLOT_W = $clog2(WINDOW);

  logic signed [CODE_W-1:0] mem_r [WINDOW];
  logic [WINDOW-1:0]        valid_r;
  logic [SLOT_W-1:0]        slot_r;
  logic signed [CODE_W-1:0] old_r;
  logic signed [CODE_W-1:0] code_r;
  logic                     old_vld_r;
  logic                     step_r;
  logic                     done_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [CODE_W-1:0] old_term;

  // Code store: the old entry is read out as the new one is written.
  always_ff @(posedge clk) begin
    if (req.upd) begin
      mem_r[slot_r] <= req.code;
      old_r         <= mem_r[slot_r];
      code_r        <= req.code;
    end
  end

  // An entry never written since reset counts as zero.
  assign old_term = old_vld_r ? old_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      slot_r    <= '0;
      old_vld_r <= 1'b0;
      step_r    <= 1'b0;
      done_r    <= 1'b0;
      sum_r     <= '0;
    end else begin
      step_r <= req.upd;
      done_r <= step_r;
      if (req.upd) begin
        old_vld_r       <= valid_r[slot_r];
        valid_r[slot_r] <= 1'b1;
        slot_r          <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      end
      if (step_r) begin
        sum_r <= sum_r + SUM_W'(code_r) - SUM_W'(old_term);
      end
    end
  end

  assign sum  = sum_r;
  assign done = done_r;

endmodule

// ----- sv/tavg_core.sv -----
// Sequencer that turns the running sum into voltage and temperatures.
`timescale 1ns / 1ps

module tavg_core #(
  parameter int WINDOW = 30
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  tavg_pkg::cfg_t                                    cfg,
  input  logic                                              start,
  input  logic signed [tavg_pkg::CODE_W-1:0]                code,
  output logic                                              idle,
  output tavg_pkg::ring_req_t                               rreq,
  input  logic signed [tavg_pkg::CODE_W+$clog2(WINDOW)-1:0] ring_sum,
  input  logic                                              ring_done,
  output tavg_pkg::mul_req_t                                mreq,
  input  tavg_pkg::mul_rsp_t                                mrsp,
  output tavg_pkg::div_req_t                                dreq,
  input  tavg_pkg::div_rsp_t                                drsp,
  output tavg_pkg::res_t                                    res,
  input  logic                                              res_take
);
  import tavg_pkg::*;

  localparam int SUM_W = CODE_W + $clog2(WINDOW);
  localparam int VDIV  = 1000 * WINDOW;

  typedef enum logic [4:0] {
    S_IDLE, S_RING, S_VMUL, S_VDIV, S_CHECK, S_LOAD, S_NORM, S_SQ, S_ACC,
    S_LQI, S_LQ, S_L2, S_CL2, S_LI, S_SCHK, S_CK, S_TFI, S_TF, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic                  sgn_r, sgn_nxt;
  logic [AVG_W-1:0]      v_r, v_nxt;
  logic signed [LG_W-1:0] lg_r, lg_nxt;
  logic [LOG_W-1:0]      x_r, x_nxt;
  logic [EXP_W-1:0]      e_r, e_nxt;
  logic [LOG_W-1:0]      frac_r, frac_nxt;
  logic [SQ_CNT_W-1:0]   it_r, it_nxt;
  logic [1:0]            lidx_r, lidx_nxt;
  logic [LQM_W-1:0]      lqmag_r, lqmag_nxt;
  logic                  lqneg_r, lqneg_nxt;
  logic signed [S_W-1:0] s_r, s_nxt;
  logic [TC_W-1:0]       tc_r, tc_nxt;
  logic [TF_W-1:0]       tf_r, tf_nxt;
  logic [ST_W-1:0]       st_r, st_nxt;
  ring_req_t             rreq_r, rreq_nxt;
  mul_req_t              mreq_r, mreq_nxt;
  div_req_t              dreq_r, dreq_nxt;

  // Next-state and datapath logic of the sequence
  always_comb begin
    logic [SUM_W-1:0]   sum_mag;
    logic [DIV_NW-1:0]  q;
    logic [31:0]        sq_t;
    logic [MANT_W-1:0]  m_new;
    logic [EXP_W+LOG_W-1:0] term;
    logic [LG_W-1:0]    lg_mag;
    logic [MUL_PW-1:0]  pm1;
    logic               lq_neg;
    logic [LQM_W-1:0]   lq_sh;
    logic [LQM_W-1:0]   lq_mag;
    logic [56:0]        inner_sum;
    logic [INNER_W-1:0] inner;
    logic               li_neg;
    logic [S_W-1:0]     li_sh;
    logic [TC_W-1:0]    tc_mag;
    logic [DIV_NW-1:0]  tf_num;
    logic [TF_W-1:0]    tf_q;

    sum_mag   = ring_sum[SUM_W-1] ? (~ring_sum + 1'b1) : ring_sum;
    q         = drsp.q;
    sq_t      = mrsp.p[61:30];
    m_new     = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
    term      = {e_r, frac_r};
    lg_mag    = lg_r[LG_W-1] ? (~lg_r + 1'b1) : lg_r;
    pm1       = mrsp.p - 1'b1;
    lq_neg    = lg_r[LG_W-1] && (mrsp.p != '0);
    lq_sh     = lq_neg ? pm1[38+LQM_W-1:38] : mrsp.p[38+LQM_W-1:38];
    lq_mag    = lq_neg ? lq_sh + 1'b1 : lq_sh;
    inner_sum = 57'(cfg.coef_b) + 57'(mrsp.p[MUL_PW-1:16]);
    inner     = inner_sum[8+INNER_W-1:8];
    li_neg    = lqneg_r && (mrsp.p != '0);
    li_sh     = li_neg ? pm1[8+S_W-1:8] : mrsp.p[8+S_W-1:8];
    tc_mag    = tc_r[TC_W-1] ? (~tc_r + 1'b1) : tc_r;
    tf_num    = (DIV_NW'(tc_mag) << 3) + DIV_NW'(tc_mag) + DIV_NW'(2);
    tf_q      = TF_W'(q[TC_W-1:0]);

    state_nxt = state_r;
    sgn_nxt   = sgn_r;
    v_nxt     = v_r;
    lg_nxt    = lg_r;
    x_nxt     = x_r;
    e_nxt     = e_r;
    frac_nxt  = frac_r;
    it_nxt    = it_r;
    lidx_nxt  = lidx_r;
    lqmag_nxt = lqmag_r;
    lqneg_nxt = lqneg_r;
    s_nxt     = s_r;
    tc_nxt    = tc_r;
    tf_nxt    = tf_r;
    st_nxt    = st_r;
    rreq_nxt       = rreq_r;
    rreq_nxt.upd   = 1'b0;
    mreq_nxt       = mreq_r;
    mreq_nxt.start = 1'b0;
    dreq_nxt       = dreq_r;
    dreq_nxt.start = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          rreq_nxt  = '{upd: 1'b1, code: code};
          state_nxt = S_RING;
        end
      end
      // Scale the magnitude of the sum by the ADC step.
      S_RING: begin
        if (ring_done) begin
          sgn_nxt   = ring_sum[SUM_W-1];
          mreq_nxt  = '{start: 1'b1, a: MUL_AW'(sum_mag), b: MUL_BW'(cfg.lsb)};
          state_nxt = S_VMUL;
        end
      end
      S_VMUL: begin
        if (mrsp.done) begin
          dreq_nxt  = '{start: 1'b1, n: mrsp.p[DIV_NW-1:0], d: DIV_DW'(VDIV)};
          state_nxt = S_VDIV;
        end
      end
      // Apply the sign, truncating toward zero, and saturate.
      S_VDIV: begin
        if (drsp.done) begin
          if (!sgn_r) begin
            v_nxt = (q > DIV_NW'(AVG_MAX)) ? AVG_MAX : q[AVG_W-1:0];
          end else begin
            v_nxt = (q > DIV_NW'(AVG_MIN)) ? AVG_MIN : (~q[AVG_W-1:0] + 1'b1);
          end
          state_nxt = S_CHECK;
        end
      end
      // The divider relation needs 0 < v < supply and a nonzero resistor.
      S_CHECK: begin
        if (v_r[AVG_W-1] || v_r == '0 || v_r >= AVG_W'(cfg.supply) ||
            cfg.fixed == '0) begin
          tc_nxt    = '0;
          tf_nxt    = '0;
          st_nxt    = ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          lg_nxt    = '0;
          lidx_nxt  = '0;
          st_nxt    = ST_VALID;
          state_nxt = S_LOAD;
        end
      end
      // Pick the operand of the next log2 term.
      S_LOAD: begin
        case (lidx_r)
          2'd0:    x_nxt = LOG_W'(cfg.fixed);
          2'd1:    x_nxt = LOG_W'(cfg.supply - v_r[SUP_W-1:0]);
          default: x_nxt = v_r;
        endcase
        e_nxt     = EXP_W'(LOG_W - 1);
        state_nxt = S_NORM;
      end
      // Shift left one place a cycle until the top bit is set.
      S_NORM: begin
        if (x_r[LOG_W-1]) begin
          frac_nxt  = '0;
          it_nxt    = SQ_CNT_W'(LOG_W);
          mreq_nxt  = '{start: 1'b1, a: MUL_AW'({x_r, 7'b0}), b: MUL_BW'({x_r, 7'b0})};
          state_nxt = S_SQ;
        end else begin
          x_nxt = x_r << 1;
          e_nxt = e_r - 1'b1;
        end
      end
      // Each squaring of the mantissa yields one fraction bit.
      S_SQ: begin
        if (mrsp.done) begin
          frac_nxt = {frac_r[LOG_W-2:0], sq_t[31]};
          it_nxt   = it_r - 1'b1;
          if (it_r == SQ_CNT_W'(1)) begin
            state_nxt = S_ACC;
          end else begin
            mreq_nxt = '{start: 1'b1, a: MUL_AW'(m_new), b: MUL_BW'(m_new)};
          end
        end
      end
      // ln R = ln fixed + ln(supply - v) - ln v, all in log2 for now.
      S_ACC: begin
        if (lidx_r == 2'd2) begin
          lg_nxt    = lg_r - LG_W'(term);
          state_nxt = S_LQI;
        end else begin
          lg_nxt    = lg_r + LG_W'(term);
          lidx_nxt  = lidx_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LQI: begin
        mreq_nxt  = '{start: 1'b1, a: MUL_AW'(lg_mag), b: LN2_Q30};
        state_nxt = S_LQ;
      end
      // Convert to natural log in Q16, rounding toward minus infinity.
      S_LQ: begin
        if (mrsp.done) begin
          lqneg_nxt = lq_neg;
          lqmag_nxt = lq_mag;
          mreq_nxt  = '{start: 1'b1, a: MUL_AW'(lq_mag), b: MUL_BW'(lq_mag)};
          state_nxt = S_L2;
        end
      end
      S_L2: begin
        if (mrsp.done) begin
          mreq_nxt  = '{start: 1'b1, a: mrsp.p[16+MUL_AW-1:16], b: cfg.coef_c};
          state_nxt = S_CL2;
        end
      end
      S_CL2: begin
        if (mrsp.done) begin
          mreq_nxt  = '{start: 1'b1, a: MUL_AW'(inner), b: MUL_BW'(lqmag_r)};
          state_nxt = S_LI;
        end
      end
      // Inverse temperature in Q40.
      S_LI: begin
        if (mrsp.done) begin
          s_nxt     = S_W'(cfg.coef_a) + (li_neg ? ~li_sh : li_sh);
          state_nxt = S_SCHK;
        end
      end
      // A nonpositive cubic reads as unbounded hot.
      S_SCHK: begin
        if (s_r[S_W-1] || s_r == '0) begin
          tc_nxt    = TC_LIMIT;
          st_nxt    = ST_SAT;
          state_nxt = S_TFI;
        end else begin
          dreq_nxt  = '{start: 1'b1, n: CK_NUM + DIV_NW'(s_r[S_W-1:1]),
                        d: DIV_DW'(s_r)};
          state_nxt = S_CK;
        end
      end
      // Centi-Kelvin to centi-Celsius, clamped at the hot end.
      S_CK: begin
        if (drsp.done) begin
          if (q > CK_LIMIT) begin
            tc_nxt = TC_LIMIT;
            st_nxt = ST_SAT;
          end else begin
            tc_nxt = q[TC_W-1:0] - KELVIN_CENTI;
          end
          state_nxt = S_TFI;
        end
      end
      S_TFI: begin
        dreq_nxt  = '{start: 1'b1, n: tf_num, d: TF_DIVISOR};
        state_nxt = S_TF;
      end
      // Fahrenheit rounds half away from zero.
      S_TF: begin
        if (drsp.done) begin
          tf_nxt    = tc_r[TC_W-1] ? (TF_OFFSET - tf_q) : (TF_OFFSET + tf_q);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rreq_r.upd   <= 1'b0;
      mreq_r.start <= 1'b0;
      dreq_r.start <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sgn_r   <= sgn_nxt;
      v_r     <= v_nxt;
      lg_r    <= lg_nxt;
      x_r     <= x_nxt;
      e_r     <= e_nxt;
      frac_r  <= frac_nxt;
      it_r    <= it_nxt;
      lidx_r  <= lidx_nxt;
      lqmag_r <= lqmag_nxt;
      lqneg_r <= lqneg_nxt;
      s_r     <= s_nxt;
      tc_r    <= tc_nxt;
      tf_r    <= tf_nxt;
      st_r    <= st_nxt;
      rreq_r  <= rreq_nxt;
      mreq_r  <= mreq_nxt;
      dreq_r  <= dreq_nxt;
    end
  end

  assign idle       = (state_r == S_IDLE);
  assign rreq       = rreq_r;
  assign mreq       = mreq_r;
  assign dreq       = dreq_r;
  assign res.valid  = (state_r == S_DONE);
  assign res.avg    = v_r;
  assign res.tc     = tc_r;
  assign res.tf     = tf_r;
  assign res.status = st_r;

  `include "thermistor_avg_temperature_top_assert.svh"

  // A product may only come back while the sequence waits for one.
  `TAVG_ASSERT_NOW(a_mul_done_expected, mrsp.done, state_r == S_VMUL || state_r == S_SQ || state_r == S_LQ || state_r == S_L2 || state_r == S_CL2 || state_r == S_LI, "multiplier result arrived in a state that does not wait for it")
  // A quotient may only come back while the sequence waits for one.
  `TAVG_ASSERT_NOW(a_div_done_expected, drsp.done, state_r == S_VDIV || state_r == S_CK || state_r == S_TF, "divider result arrived in a state that does not wait for it")
  // A finished result stays until the output side takes it.
  `TAVG_ASSERT_NEXT(a_result_held, state_r == S_DONE && !res_take, state_r == S_DONE, "pending result was dropped")
  // An invalid divider voltage reports both temperatures as zero.
  `TAVG_ASSERT_NOW(a_range_zero, state_r == S_DONE && st_r == ST_RANGE, tc_r == '0 && tf_r == '0, "temperatures not cleared for an invalid voltage")

endmodule

// ----- sv/thermistor_avg_temperature_top.sv -----
// Top level of the thermistor moving-average temperature block.
//
//  Port group  Direction  Beat contents (lowest bits first)
//  in_*        input      tdata: sample_code[15:0]
//  out_*       output     tdata: avg_microvolts, temp_c_centi, temp_f_centi; tuser: status
//  cfg_*       input      write enable, register index, write data
//
// From acceptance to the output register, a sample whose divider voltage is out of range
// skips the logarithm and all later steps; a sample with a nonpositive cubic skips the
// centi-Kelvin division. Otherwise the time is set by the 72 mantissa squarings of the
// three log2 terms in the 4-bit serial multiplier, the normalising shifts, and three
// 56-step passes through the bit-serial divider; a nonpositive cubic needs two of them.
// Reset clears the code ring at once through per-entry valid bits.
// A new sample is taken once the previous result has moved to the output register.
`timescale 1ns / 1ps

module thermistor_avg_temperature_top #(
  parameter int WINDOW = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample_code[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // avg_microvolts[23:0], temp_c_centi[39:24],
                                  // temp_f_centi[56:40], zero[63:57]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import tavg_pkg::*;

  localparam int SUM_W = CODE_W + $clog2(WINDOW);

  cfg_t                    cfg_r;
  ring_req_t               rreq;
  logic signed [SUM_W-1:0] ring_sum;
  logic                    ring_done;
  mul_req_t                mreq;
  mul_rsp_t                mrsp;
  div_req_t                dreq;
  div_rsp_t                drsp;
  res_t                    res;
  logic                    core_idle;
  logic                    res_take;
  logic                    out_tvalid_r;
  logic [63:0]             out_tdata_r;
  logic [1:0]              out_tuser_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lsb    <= RST_LSB;
      cfg_r.supply <= RST_SUPPLY;
      cfg_r.fixed  <= RST_FIXED;
      cfg_r.coef_a <= RST_COEF_A;
      cfg_r.coef_b <= RST_COEF_B;
      cfg_r.coef_c <= RST_COEF_C;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LSB:    cfg_r.lsb    <= cfg_wdata[LSB_W-1:0];
        REG_SUPPLY: cfg_r.supply <= cfg_wdata[SUP_W-1:0];
        REG_FIXED:  cfg_r.fixed  <= cfg_wdata[FIX_W-1:0];
        REG_COEF_A: cfg_r.coef_a <= cfg_wdata[COEF_W-1:0];
        REG_COEF_B: cfg_r.coef_b <= cfg_wdata[COEF_W-1:0];
        REG_COEF_C: cfg_r.coef_c <= cfg_wdata[COEF_W-1:0];
        default:    ;
      endcase
    end
  end

  assign in_tready = core_idle;

  tavg_ring #(.WINDOW(WINDOW)) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rreq),
    .sum   (ring_sum),
    .done  (ring_done)
  );

  tavg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  tavg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  tavg_core #(.WINDOW(WINDOW)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_tvalid & in_tready),
    .code      (signed'(in_tdata)),
    .idle      (core_idle),
    .rreq      (rreq),
    .ring_sum  (ring_sum),
    .ring_done (ring_done),
    .mreq      (mreq),
    .mrsp      (mrsp),
    .dreq      (dreq),
    .drsp      (drsp),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register: a finished beat moves in when the slot is free or leaving.
  assign res_take = res.valid && (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      if (res_take) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {7'b0, res.tf, res.tc, res.avg};
        out_tuser_r  <= res.status;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
